[rtl/core/wstok_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wstok_pkg - shared types and constants of the word and string tokenizer
// Event codes, lexer modes, result and queue-push bundles, character codes.
// ----------------------------------------------------------------------------
package wstok_pkg;

  localparam int LEN_W          = 10;
  localparam int MAX_LEN_RESET  = 255;
  localparam int FIFO_DEPTH_DEF = 8;
  localparam int PUSH_MAX       = 3;

  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LC_N   = 8'h6E;
  localparam logic [7:0] CH_LC_T   = 8'h74;
  localparam logic [7:0] CH_LC_R   = 8'h72;
  localparam logic [7:0] CH_LC_B   = 8'h62;
  localparam logic [7:0] CH_LC_F   = 8'h66;
  localparam logic [7:0] CH_LC_A   = 8'h61;
  localparam logic [7:0] CH_LC_V   = 8'h76;
  localparam logic [7:0] CH_ZERO   = 8'h30;

  localparam logic [7:0] CH_BS_CTL  = 8'h08;
  localparam logic [7:0] CH_FF_CTL  = 8'h0C;
  localparam logic [7:0] CH_BEL_CTL = 8'h07;
  localparam logic [7:0] CH_VT_CTL  = 8'h0B;
  localparam logic [7:0] CH_NUL     = 8'h00;

  // register byte addresses, word index taken from paddr[2]
  localparam logic REG_MAX_LEN = 1'b0;

  typedef enum logic [2:0] {
    EV_WBYTE  = 3'd0,
    EV_SBYTE  = 3'd1,
    EV_WEND   = 3'd2,
    EV_SEND   = 3'd3,
    EV_LONG   = 3'd4,
    EV_UNTERM = 3'd5,
    EV_INEND  = 3'd6
  } ev_t;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_WORD = 3'd1,
    MODE_STR  = 3'd2,
    MODE_ESC  = 3'd3,
    MODE_CMT  = 3'd4,
    MODE_ERR  = 3'd5
  } mode_t;

  typedef struct packed {
    ev_t        ev;
    logic [7:0] data;
    logic       last;
  } result_t;

  typedef struct packed {
    logic [1:0]           cnt;
    result_t [PUSH_MAX-1:0] ent;
  } push_t;

  typedef struct packed {
    mode_t            mode;
    logic             slash;
    logic [LEN_W-1:0] len;
  } lex_stat_t;

endpackage

[rtl/core/wstok_lex.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wstok_lex - lexer state and per-byte decode
// Holds mode, held slash and token length; turns one byte or end-of-input
// into up to three result beats combinationally.
// ----------------------------------------------------------------------------
module wstok_lex
  import wstok_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic [7:0]       item_byte,
  input  logic             item_eoi,
  input  logic [LEN_W-1:0] max_len,
  output push_t            push_o,
  output lex_stat_t        stat_o
);

  mode_t            mode_r, mode_nxt;
  logic             sp_r, sp_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;

  logic             is_ws, is_sl, is_q, is_bs, is_nl;
  logic             full_cur, full_sl, full_nx, max_zero;
  logic [LEN_W-1:0] eff_len, len_sl1, len_cur1, len_sl2;
  logic [7:0]       esc_byte;

  result_t [PUSH_MAX-1:0] ent_v;
  logic [1:0]             n_v;

  function automatic result_t mk(input ev_t e, input logic [7:0] d);
    result_t r;
    r.ev   = e;
    r.data = d;
    r.last = 1'b0;
    return r;
  endfunction

  assign is_ws = (item_byte == CH_SPACE) || (item_byte >= CH_TAB && item_byte <= CH_CR);
  assign is_sl = (item_byte == CH_SLASH);
  assign is_q  = (item_byte == CH_QUOTE);
  assign is_bs = (item_byte == CH_BSLASH);
  assign is_nl = (item_byte == CH_NL);

  // a held slash opens a fresh word when seen from idle
  assign eff_len  = (mode_r == MODE_IDLE) ? '0 : len_r;
  assign full_cur = (len_r >= max_len);
  assign full_sl  = (eff_len >= max_len);
  assign len_sl1  = eff_len + LEN_W'(1);
  assign len_sl2  = len_sl1 + LEN_W'(1);
  assign full_nx  = (len_sl1 >= max_len);
  assign len_cur1 = len_r + LEN_W'(1);
  assign max_zero = (max_len == '0);

  always_comb begin
    case (item_byte)
      CH_LC_N: esc_byte = CH_NL;
      CH_LC_T: esc_byte = CH_TAB;
      CH_LC_R: esc_byte = CH_CR;
      CH_LC_B: esc_byte = CH_BS_CTL;
      CH_LC_F: esc_byte = CH_FF_CTL;
      CH_LC_A: esc_byte = CH_BEL_CTL;
      CH_LC_V: esc_byte = CH_VT_CTL;
      CH_ZERO: esc_byte = CH_NUL;
      default: esc_byte = item_byte;
    endcase
  end

  // next state
  always_comb begin
    mode_nxt = mode_r;
    sp_nxt   = sp_r;
    len_nxt  = len_r;
    if (item_eoi) begin
      mode_nxt = MODE_IDLE;
      sp_nxt   = 1'b0;
      len_nxt  = '0;
    end else begin
      case (mode_r)
        MODE_CMT: begin
          if (is_nl) mode_nxt = MODE_IDLE;
        end
        MODE_STR: begin
          if (is_q) begin
            mode_nxt = MODE_IDLE;
            len_nxt  = '0;
          end else if (full_cur) begin
            mode_nxt = MODE_ERR;
            len_nxt  = '0;
          end else if (is_bs) begin
            mode_nxt = MODE_ESC;
          end else begin
            len_nxt = len_cur1;
          end
        end
        MODE_ESC: begin
          if (full_cur) begin
            mode_nxt = MODE_ERR;
            len_nxt  = '0;
          end else begin
            mode_nxt = MODE_STR;
            len_nxt  = len_cur1;
          end
        end
        MODE_IDLE, MODE_WORD: begin
          if (sp_r) begin
            sp_nxt = 1'b0;
            if (is_sl) begin
              mode_nxt = MODE_CMT;
              len_nxt  = '0;
            end else if (full_sl) begin
              mode_nxt = MODE_ERR;
              len_nxt  = '0;
            end else if (is_ws) begin
              mode_nxt = MODE_IDLE;
              len_nxt  = '0;
            end else if (full_nx) begin
              mode_nxt = MODE_ERR;
              len_nxt  = '0;
            end else begin
              mode_nxt = MODE_WORD;
              len_nxt  = len_sl2;
            end
            // slash after the held slash is handled above as a comment
          end else if (mode_r == MODE_IDLE) begin
            if (is_ws) begin
              mode_nxt = MODE_IDLE;
            end else if (is_sl) begin
              sp_nxt = 1'b1;
            end else if (is_q) begin
              mode_nxt = MODE_STR;
              len_nxt  = '0;
            end else if (max_zero) begin
              mode_nxt = MODE_ERR;
              len_nxt  = '0;
            end else begin
              mode_nxt = MODE_WORD;
              len_nxt  = LEN_W'(1);
            end
          end else begin
            if (is_ws) begin
              mode_nxt = MODE_IDLE;
              len_nxt  = '0;
            end else if (is_sl) begin
              sp_nxt = 1'b1;
            end else if (full_cur) begin
              mode_nxt = MODE_ERR;
              len_nxt  = '0;
            end else begin
              len_nxt = len_cur1;
            end
          end
        end
        default: begin
          mode_nxt = mode_r;
        end
      endcase
    end
  end

  // result beats
  always_comb begin
    ent_v = '0;
    n_v   = '0;
    if (item_eoi) begin
      if ((mode_r == MODE_IDLE && sp_r) || mode_r == MODE_WORD) begin
        if (sp_r && full_sl) begin
          ent_v[n_v] = mk(EV_LONG, '0);
          n_v        = n_v + 2'd1;
        end else begin
          if (sp_r) begin
            ent_v[n_v] = mk(EV_WBYTE, CH_SLASH);
            n_v        = n_v + 2'd1;
          end
          ent_v[n_v] = mk(EV_WEND, '0);
          n_v        = n_v + 2'd1;
        end
      end else if (mode_r == MODE_STR || mode_r == MODE_ESC) begin
        ent_v[n_v] = mk(EV_UNTERM, '0);
        n_v        = n_v + 2'd1;
      end
      ent_v[n_v] = mk(EV_INEND, '0);
      n_v        = n_v + 2'd1;
    end else begin
      case (mode_r)
        MODE_STR: begin
          if (is_q) begin
            ent_v[n_v] = mk(EV_SEND, '0);
            n_v        = n_v + 2'd1;
          end else if (full_cur) begin
            ent_v[n_v] = mk(EV_LONG, '0);
            n_v        = n_v + 2'd1;
          end else if (!is_bs) begin
            ent_v[n_v] = mk(EV_SBYTE, item_byte);
            n_v        = n_v + 2'd1;
          end
        end
        MODE_ESC: begin
          if (full_cur) begin
            ent_v[n_v] = mk(EV_LONG, '0);
          end else begin
            ent_v[n_v] = mk(EV_SBYTE, esc_byte);
          end
          n_v = n_v + 2'd1;
        end
        MODE_IDLE, MODE_WORD: begin
          if (sp_r) begin
            if (is_sl) begin
              if (mode_r == MODE_WORD) begin
                ent_v[n_v] = mk(EV_WEND, '0);
                n_v        = n_v + 2'd1;
              end
            end else if (full_sl) begin
              ent_v[n_v] = mk(EV_LONG, '0);
              n_v        = n_v + 2'd1;
            end else begin
              ent_v[n_v] = mk(EV_WBYTE, CH_SLASH);
              n_v        = n_v + 2'd1;
              if (is_ws) begin
                ent_v[n_v] = mk(EV_WEND, '0);
                n_v        = n_v + 2'd1;
              end else if (full_nx) begin
                ent_v[n_v] = mk(EV_LONG, '0);
                n_v        = n_v + 2'd1;
              end else begin
                ent_v[n_v] = mk(EV_WBYTE, item_byte);
                n_v        = n_v + 2'd1;
              end
            end
          end else if (mode_r == MODE_IDLE) begin
            if (!is_ws && !is_sl && !is_q) begin
              ent_v[n_v] = max_zero ? mk(EV_LONG, '0) : mk(EV_WBYTE, item_byte);
              n_v        = n_v + 2'd1;
            end
          end else begin
            if (is_ws) begin
              ent_v[n_v] = mk(EV_WEND, '0);
              n_v        = n_v + 2'd1;
            end else if (!is_sl) begin
              ent_v[n_v] = full_cur ? mk(EV_LONG, '0) : mk(EV_WBYTE, item_byte);
              n_v        = n_v + 2'd1;
            end
          end
        end
        default: begin
          n_v = '0;
        end
      endcase
    end
    case (n_v)
      2'd1:    ent_v[0].last = 1'b1;
      2'd2:    ent_v[1].last = 1'b1;
      2'd3:    ent_v[2].last = 1'b1;
      default: ent_v[0].last = ent_v[0].last;
    endcase
  end

  assign push_o.cnt = step ? n_v : 2'd0;
  assign push_o.ent = ent_v;

  assign stat_o.mode  = mode_r;
  assign stat_o.slash = sp_r;
  assign stat_o.len   = len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      sp_r   <= 1'b0;
      len_r  <= '0;
    end else if (step) begin
      mode_r <= mode_nxt;
      sp_r   <= sp_nxt;
      len_r  <= len_nxt;
    end
  end

endmodule

[rtl/core/wstok_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wstok_fifo - result queue
// Takes up to three result beats per cycle, hands out one beat per cycle when popped.
// ----------------------------------------------------------------------------
module wstok_fifo
  import wstok_pkg::*;
#(
  parameter int DEPTH = FIFO_DEPTH_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  input  push_t   push_i,
  input  logic    pop,
  output result_t head_o,
  output logic    not_empty,
  output logic    room
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  result_t         mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [PW-1:0]   slot_addr [PUSH_MAX];

  function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] p, input logic [1:0] k);
    logic [PW:0] s;
    s = {1'b0, p} + (PW+1)'(k);
    if (s >= (PW+1)'(DEPTH)) s = s - (PW+1)'(DEPTH);
    return s[PW-1:0];
  endfunction

  always_comb begin
    for (int k = 0; k < PUSH_MAX; k++) begin
      slot_addr[k] = wrap_add(wr_ptr_r, 2'(k));
    end
  end

  assign wr_ptr_nxt = wrap_add(wr_ptr_r, push_i.cnt);
  assign rd_ptr_nxt = pop ? wrap_add(rd_ptr_r, 2'd1) : rd_ptr_r;
  assign cnt_nxt    = cnt_r + CW'(push_i.cnt) - CW'(pop);

  assign head_o    = mem_r[rd_ptr_r];
  assign not_empty = (cnt_r != '0);
  assign room      = ((CW+1)'(DEPTH) - (CW+1)'(cnt_r)) >= (CW+1)'(PUSH_MAX);

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      for (int k = 0; k < PUSH_MAX; k++) begin
        if (2'(k) < push_i.cnt && slot_addr[k] == PW'(i)) begin
          mem_r[i] <= push_i.ent[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

[rtl/core/word_and_string_tokenizer_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// word_and_string_tokenizer_unit - streaming word and string lexer
// Byte-in, event-out lexer with // comments and string escapes.
// ----------------------------------------------------------------------------
// Takes one source byte (or an end-of-input mark) per beat and produces zero
// to three result beats: word bytes, string bytes with escapes translated,
// token-end, error and input-end events. An accepted byte is held in the
// input register, decoded combinationally against the lexer state, and
// its results enter an eight-entry result queue that drains one beat per
// cycle while the receiver does not stall. A new byte is taken every cycle
// while the queue has at least three free entries, so the sustained rate
// is one byte per cycle as long as bytes average no more than one result
// each; bytes that end a token add one extra output beat. After a too-long
// error the remaining bytes up to end of input are dropped.
// ----------------------------------------------------------------------------
module word_and_string_tokenizer_unit
  import wstok_pkg::*;
#(
  parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        in_end_of_input,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_event_res,
  output logic [7:0]  out_byte,
  output logic        out_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic             in_full_r, in_full_nxt;
  logic [7:0]       byte_r;
  logic             eoi_r;
  logic [LEN_W-1:0] max_len_r;
  logic             room, advance, accept, pop;
  push_t            push;
  lex_stat_t        stat;
  result_t          head;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MAX_LEN) ? 32'(max_len_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= LEN_W'(MAX_LEN_RESET);
    end else if (psel && penable && pwrite && paddr[2] == REG_MAX_LEN) begin
      max_len_r <= pwdata[LEN_W-1:0];
    end
  end

  // hold the beat until the queue can take its worst-case result count
  assign advance     = in_full_r && room;
  assign in_stall    = in_full_r && !room;
  assign accept      = in_valid && !in_stall;
  assign in_full_nxt = accept || (in_full_r && !advance);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_full_r <= 1'b0;
    end else begin
      in_full_r <= in_full_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_r <= in_byte;
      eoi_r  <= in_end_of_input;
    end
  end

  wstok_lex u_lex (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .item_byte (byte_r),
    .item_eoi  (eoi_r),
    .max_len   (max_len_r),
    .push_o    (push),
    .stat_o    (stat)
  );

  assign pop = out_valid && !out_stall;

  wstok_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_i    (push),
    .pop       (pop),
    .head_o    (head),
    .not_empty (out_valid),
    .room      (room)
  );

  assign out_event_res = head.ev;
  assign out_byte      = head.data;
  assign out_last      = head.last;

  a_push_on_step: assert property (@(posedge clk) disable iff (!rst_n)
    push.cnt != 2'd0 |-> advance)
    else $error("result beats pushed without a decoded byte");

  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    stat.mode == MODE_ERR && !(advance && eoi_r) |=> stat.mode == MODE_ERR)
    else $error("error mode left before end of input");

  a_eoi_clears: assert property (@(posedge clk) disable iff (!rst_n)
    advance && eoi_r |=> stat.mode == MODE_IDLE && !stat.slash && stat.len == '0)
    else $error("lexer state not cleared after end of input");

  a_slash_mode: assert property (@(posedge clk) disable iff (!rst_n)
    stat.slash |-> (stat.mode == MODE_IDLE || stat.mode == MODE_WORD))
    else $error("slash held outside idle or word mode");

  a_hold_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_full_r && !room |=> in_full_r && $stable(byte_r) && $stable(eoi_r))
    else $error("held input beat lost while queue full");

endmodule

[tb/sv/word_and_string_tokenizer_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// word_and_string_tokenizer_unit_tb - self-checking bench for the tokenizer
// Feeds source bytes and end-of-input marks through the valid/stall input,
// predicts the word, string, error and end events of each accepted beat with
// a lexer model kept in step with the token length limit, and compares every
// result beat field by field in order. Runs several limit settings, from zero
// to the top of the range, with random idling, a long receiver hold-off that
// fills the block, and a sender pause that drains it.
// ----------------------------------------------------------------------------
module word_and_string_tokenizer_unit_tb;
  import wstok_pkg::*;

  localparam int IDLE_PCT      = 37;
  localparam int HOLDOFF       = 80;
  localparam int SETTLE        = 16;
  localparam int WATCHDOG      = 1000;
  localparam int REPORT_LIMIT  = 10;
  localparam logic [2:0] MAX_LEN_ADDR = {REG_MAX_LEN, 2'b00};
  localparam logic [2:0] SPARE_ADDR   = {~REG_MAX_LEN, 2'b00};

  typedef struct {
    logic [7:0] ch;
    logic       eoi;
    bit         drain;
  } src_item_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte = 8'h00;
  logic        in_end_of_input = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_event_res;
  logic [7:0]  out_byte;
  logic        out_last;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  src_item_t src_items[$];
  result_t   lexeme_events[$];
  result_t   burst[$];
  int        items_made;
  bit        drain_next;
  bit        calm;
  int        holdoff_req;
  int        holdoff_seen;
  int        holdoff_left;
  int        token_mismatches;
  int        quiet_cycles;

  // lexer state as the block should hold it
  mode_t            tok_mode;
  bit               slash_held;
  logic [LEN_W-1:0] tok_len;
  logic [LEN_W-1:0] len_limit;

  word_and_string_tokenizer_unit u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_byte         (in_byte),
    .in_end_of_input (in_end_of_input),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_event_res   (out_event_res),
    .out_byte        (out_byte),
    .out_last        (out_last),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always #2 clk = ~clk;

  // --------------------------------------------------------------------------
  // Lexer prediction
  // --------------------------------------------------------------------------
  function automatic bit is_blank(logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic void put_event(ev_t e, logic [7:0] c);
    result_t r;
    r.ev   = e;
    r.data = c;
    r.last = 1'b0;
    burst.push_back(r);
  endfunction

  function automatic void too_long();
    put_event(EV_LONG, CH_NUL);
    tok_mode   = MODE_ERR;
    slash_held = 1'b0;
    tok_len    = '0;
  endfunction

  function automatic bit take_byte(ev_t e, logic [7:0] c);
    if (tok_len >= len_limit) begin
      too_long();
      return 1'b0;
    end
    put_event(e, c);
    tok_len = tok_len + LEN_W'(1);
    return 1'b1;
  endfunction

  function automatic void word_char(logic [7:0] c);
    if (is_blank(c)) begin
      put_event(EV_WEND, CH_NUL);
      tok_mode = MODE_IDLE;
      tok_len  = '0;
    end else if (c == CH_SLASH) begin
      slash_held = 1'b1;
    end else begin
      void'(take_byte(EV_WBYTE, c));
    end
  endfunction

  function automatic void predict_lexemes(logic [7:0] c, logic eoi);
    bit         ok;
    logic [7:0] esc;
    burst = {};
    if (eoi) begin
      if (tok_mode == MODE_IDLE && slash_held) begin
        tok_mode = MODE_WORD;
        tok_len  = '0;
      end
      if (tok_mode == MODE_WORD) begin
        ok = 1'b1;
        if (slash_held) begin
          slash_held = 1'b0;
          ok = take_byte(EV_WBYTE, CH_SLASH);
        end
        if (ok) put_event(EV_WEND, CH_NUL);
      end else if (tok_mode == MODE_STR || tok_mode == MODE_ESC) begin
        put_event(EV_UNTERM, CH_NUL);
      end
      put_event(EV_INEND, CH_NUL);
      tok_mode   = MODE_IDLE;
      slash_held = 1'b0;
      tok_len    = '0;
    end else begin
      case (tok_mode)
        MODE_CMT: begin
          if (c == CH_NL) tok_mode = MODE_IDLE;
        end
        MODE_STR: begin
          if (c == CH_QUOTE) begin
            put_event(EV_SEND, CH_NUL);
            tok_mode = MODE_IDLE;
            tok_len  = '0;
          end else if (c == CH_BSLASH) begin
            if (tok_len >= len_limit) too_long();
            else tok_mode = MODE_ESC;
          end else begin
            void'(take_byte(EV_SBYTE, c));
          end
        end
        MODE_ESC: begin
          tok_mode = MODE_STR;
          case (c)
            CH_LC_N: esc = CH_NL;
            CH_LC_T: esc = CH_TAB;
            CH_LC_R: esc = CH_CR;
            CH_LC_B: esc = CH_BS_CTL;
            CH_LC_F: esc = CH_FF_CTL;
            CH_LC_A: esc = CH_BEL_CTL;
            CH_LC_V: esc = CH_VT_CTL;
            CH_ZERO: esc = CH_NUL;
            default: esc = c;
          endcase
          void'(take_byte(EV_SBYTE, esc));
        end
        MODE_IDLE: begin
          if (slash_held) begin
            slash_held = 1'b0;
            if (c == CH_SLASH) begin
              tok_mode = MODE_CMT;
            end else begin
              tok_mode = MODE_WORD;
              tok_len  = '0;
              if (take_byte(EV_WBYTE, CH_SLASH)) word_char(c);
            end
          end else if (c == CH_SLASH) begin
            slash_held = 1'b1;
          end else if (c == CH_QUOTE) begin
            tok_mode = MODE_STR;
            tok_len  = '0;
          end else if (!is_blank(c)) begin
            tok_mode = MODE_WORD;
            tok_len  = '0;
            void'(take_byte(EV_WBYTE, c));
          end
        end
        MODE_WORD: begin
          if (slash_held) begin
            slash_held = 1'b0;
            if (c == CH_SLASH) begin
              put_event(EV_WEND, CH_NUL);
              tok_mode = MODE_CMT;
              tok_len  = '0;
            end else if (take_byte(EV_WBYTE, CH_SLASH)) begin
              word_char(c);
            end
          end else begin
            word_char(c);
          end
        end
        default: begin
          // error: drop bytes until end of input
        end
      endcase
    end
    if (burst.size() > 0) burst[burst.size()-1].last = 1'b1;
    foreach (burst[i]) lexeme_events.push_back(burst[i]);
  endfunction

  // --------------------------------------------------------------------------
  // Source text
  // --------------------------------------------------------------------------
  function automatic void add_item(logic [7:0] c, logic eoi);
    src_item_t it;
    it.ch    = c;
    it.eoi   = eoi;
    it.drain = drain_next;
    drain_next = 1'b0;
    src_items.push_back(it);
    items_made++;
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) add_item(s[i], 1'b0);
  endfunction

  function automatic void add_end();
    add_item(8'($urandom_range(255)), 1'b1);
  endfunction

  function automatic logic [7:0] pick_blank();
    int k;
    k = $urandom_range(5);
    return (k == 5) ? CH_SPACE : CH_TAB + 8'(k);
  endfunction

  // Mostly well-formed tokens with random content, some noise and cut text.
  function automatic void gen_source(int budget, int wmax);
    logic [7:0] esc_letters[8];
    logic [7:0] c;
    int         stop;
    int         kind;
    int         n;
    esc_letters = '{CH_LC_N, CH_LC_T, CH_LC_R, CH_LC_B, CH_LC_F, CH_LC_A, CH_LC_V,
                    CH_ZERO};
    stop = items_made + budget;
    while (items_made < stop) begin
      kind = $urandom_range(99);
      if (kind < 35) begin
        n = $urandom_range(1, wmax);
        for (int i = 0; i < n; i++) begin
          if (i > 0 && $urandom_range(7) == 0) begin
            add_item(CH_SLASH, 1'b0);
          end else begin
            do c = 8'($urandom_range(255));
            while (is_blank(c) || c == CH_SLASH || (i == 0 && c == CH_QUOTE));
            add_item(c, 1'b0);
          end
        end
        if ($urandom_range(3) == 0) begin
          add_text("//");
          add_item(8'($urandom_range(8'h21, 8'h7E)), 1'b0);
          add_item(CH_NL, 1'b0);
        end else begin
          add_item(pick_blank(), 1'b0);
        end
      end else if (kind < 60) begin
        add_item(CH_QUOTE, 1'b0);
        n = $urandom_range(0, wmax);
        for (int i = 0; i < n; i++) begin
          if ($urandom_range(3) == 0) begin
            add_item(CH_BSLASH, 1'b0);
            if ($urandom_range(8) == 8) add_item(8'($urandom_range(255)), 1'b0);
            else add_item(esc_letters[$urandom_range(7)], 1'b0);
          end else begin
            do c = 8'($urandom_range(255));
            while (c == CH_QUOTE || c == CH_BSLASH);
            add_item(c, 1'b0);
          end
        end
        if ($urandom_range(9) != 0) add_item(CH_QUOTE, 1'b0);
      end else if (kind < 72) begin
        add_text("//");
        n = $urandom_range(0, 5);
        for (int i = 0; i < n; i++) begin
          do c = 8'($urandom_range(255));
          while (c == CH_NL);
          add_item(c, 1'b0);
        end
        add_item(CH_NL, 1'b0);
      end else if (kind < 82) begin
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++) add_item(pick_blank(), 1'b0);
      end else if (kind < 90) begin
        add_item(CH_SLASH, 1'b0);
        add_item(8'($urandom_range(255)), 1'b0);
      end else if (kind < 96) begin
        add_item(8'($urandom_range(255)), 1'b0);
      end else begin
        add_end();
      end
    end
    add_end();
  endfunction

  // --------------------------------------------------------------------------
  // Configuration and phase control
  // --------------------------------------------------------------------------
  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == MAX_LEN_ADDR) len_limit = data[LEN_W-1:0];
  endtask

  // upper data bits are junk; only the low field should stick
  task automatic set_limit(input logic [LEN_W-1:0] v);
    apb_write(MAX_LEN_ADDR, ($urandom() & ~32'h3FF) | 32'(v));
  endtask

  task automatic wait_quiet();
    while (src_items.size() != 0 || in_valid || lexeme_events.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    int lim;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset limit: escapes, comments, lone and trailing slashes, odd bytes
    add_item(8'h00, 1'b0);
    add_item(8'hFF, 1'b0);
    add_text(" a\"/b//c\n\"\\q\\n\" w/");
    add_end();
    wait_quiet();

    // one-byte limit: overflow in a word, backslash in a full string
    set_limit(10'd1);
    add_text("ab\"x");
    add_end();
    add_text("\"x\\");
    add_end();
    add_text("/");
    add_end();
    wait_quiet();

    // zero limit; the spare address must leave it alone
    set_limit(10'd0);
    apb_write(SPARE_ADDR, 32'd5);
    add_text("\"\" \"");
    add_end();
    add_text("/x");
    add_end();
    wait_quiet();

    // top limit, no idling, receiver held off so the block backs up
    set_limit(10'd1023);
    calm = 1'b1;
    holdoff_req++;
    gen_source(20, 12);
    wait_quiet();
    calm = 1'b0;

    // small limit, with a full drain part way through
    lim = $urandom_range(2, 6);
    set_limit(10'(lim));
    gen_source(8, lim + 2);
    drain_next = 1'b1;
    gen_source(8, lim + 2);
    wait_quiet();

    lim = $urandom_range(7, 40);
    set_limit(10'(lim));
    gen_source(10, 12);
    wait_quiet();

    if (token_mismatches == 0 && lexeme_events.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Source driver
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (src_items.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT) &&
          (!src_items[0].drain || (!in_valid && lexeme_events.size() == 0))) begin
        in_valid        <= 1'b1;
        in_byte         <= src_items[0].ch;
        in_end_of_input <= src_items[0].eoi;
        void'(src_items.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result stall: random, calm, or a long hold-off on request
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall    <= 1'b0;
      holdoff_left <= 0;
      holdoff_seen <= 0;
    end else if (holdoff_seen != holdoff_req) begin
      holdoff_seen <= holdoff_req;
      holdoff_left <= HOLDOFF;
      out_stall    <= 1'b1;
    end else if (holdoff_left != 0) begin
      holdoff_left <= holdoff_left - 1;
      out_stall    <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: predict on each source beat, then check each result beat
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst_n) begin
      tok_mode   = MODE_IDLE;
      slash_held = 1'b0;
      tok_len    = '0;
      len_limit  = LEN_W'(MAX_LEN_RESET);
      lexeme_events.delete();
    end else begin
      if (in_valid && !in_stall) predict_lexemes(in_byte, in_end_of_input);
      if (out_valid && !out_stall) begin
        if (lexeme_events.size() == 0) begin
          if (token_mismatches < REPORT_LIMIT)
            $display("unexpected result beat: ev=%0d byte=%02h last=%0b",
                     out_event_res, out_byte, out_last);
          token_mismatches++;
        end else begin
          want = lexeme_events.pop_front();
          if (out_event_res !== want.ev || out_byte !== want.data ||
              out_last !== want.last) begin
            if (token_mismatches < REPORT_LIMIT)
              $display("result mismatch: want ev=%0d byte=%02h last=%0b, got ev=%0d byte=%02h last=%0b",
                       want.ev, want.data, want.last, out_event_res, out_byte, out_last);
            token_mismatches++;
          end
        end
      end
    end
  end

  // give up when neither side moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
